### rtl/tld_pkg.sv
package tld_pkg;

    // Default depth of the line store.
    localparam int LINE_DEPTH_DEF = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MODES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_CHAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EOF_CHAR     = 3'd4;

    localparam logic [1:0] RST_LOCAL_MODES  = 2'd3;
    localparam logic [1:0] RST_INPUT_MODES  = 2'd2;
    localparam logic [2:0] RST_OUTPUT_MODES = 3'd3;
    localparam logic [7:0] RST_ERASE_CHAR   = 8'd127;
    localparam logic [7:0] RST_EOF_CHAR     = 8'd4;

    // Result kinds.
    localparam logic [1:0] KIND_READER  = 2'd0;
    localparam logic [1:0] KIND_DISPLAY = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    // Special characters.
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [1:0] local_modes;
        logic [1:0] input_modes;
        logic [2:0] output_modes;
        logic [7:0] erase_char;
        logic [7:0] eof_char;
    } t_cfg;

    // Display bytes produced by output post-processing of one byte.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
    } t_disp;

    // What one input byte does: up to three immediate beats, an optional
    // store into the line, and an optional flush of the line afterwards.
    typedef struct packed {
        logic [2:0][7:0] data_q;
        logic [2:0][1:0] kind_q;
        logic [1:0]      count;
        logic            flush;
        logic            store;
        logic [7:0]      store_byte;
    } t_plan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

### rtl/tld_decode.sv
module tld_decode #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF,
    localparam int CW = $clog2(LINE_DEPTH + 1)
) (
    input  tld_pkg::t_cfg  i_cfg,
    input  logic           i_action,
    input  logic [7:0]     i_data,
    input  logic [CW-1:0]  i_fill,
    output tld_pkg::t_plan o_plan,
    output logic [CW-1:0]  o_fill_next
);

    function automatic tld_pkg::t_disp disp_expand(input logic [7:0] d, input logic [2:0] om);
        tld_pkg::t_disp r;
        r.two    = 1'b0;
        r.first  = d;
        r.second = tld_pkg::CH_NL;
        if (om[0] && d == tld_pkg::CH_NL && om[1]) begin
            r.two   = 1'b1;
            r.first = tld_pkg::CH_CR;
        end else if (om[0] && d == tld_pkg::CH_CR && om[2]) begin
            r.first = tld_pkg::CH_NL;
        end
        return r;
    endfunction

    logic           w_echo;
    logic           w_did_tr;
    logic [7:0]     w_tr;
    logic [7:0]     w_st;
    logic           w_full;
    logic           w_empty;
    tld_pkg::t_disp w_disp_in;
    tld_pkg::t_disp w_disp_st;

    assign w_echo   = i_cfg.local_modes[1];
    assign w_did_tr = (i_data == tld_pkg::CH_NL && i_cfg.input_modes[0])
                   || (i_data == tld_pkg::CH_CR && i_cfg.input_modes[1]);
    assign w_tr     = (i_data == tld_pkg::CH_NL && i_cfg.input_modes[0]) ? tld_pkg::CH_CR :
                      (i_data == tld_pkg::CH_CR && i_cfg.input_modes[1]) ? tld_pkg::CH_NL :
                      i_data;
    assign w_st     = (w_tr == tld_pkg::CH_ESC) ? tld_pkg::CH_CARET : w_tr;
    assign w_full   = (i_fill >= CW'(LINE_DEPTH));
    assign w_empty  = (i_fill == '0);

    assign w_disp_in = disp_expand(i_data, i_cfg.output_modes);
    assign w_disp_st = disp_expand(w_st, i_cfg.output_modes);

    always_comb begin
        o_plan      = '0;
        o_fill_next = i_fill;
        if (i_action) begin
            // Program output goes to the display with post-processing.
            o_plan.data_q[0] = w_disp_in.first;
            o_plan.kind_q[0] = tld_pkg::KIND_DISPLAY;
            o_plan.data_q[1] = w_disp_in.second;
            o_plan.kind_q[1] = tld_pkg::KIND_DISPLAY;
            o_plan.count     = w_disp_in.two ? 2'd2 : 2'd1;
        end else if (!i_cfg.local_modes[0]) begin
            // Raw mode: the echo is not post-processed.
            if (w_echo) begin
                o_plan.data_q[0] = i_data;
                o_plan.kind_q[0] = tld_pkg::KIND_DISPLAY;
                o_plan.data_q[1] = i_data;
                o_plan.kind_q[1] = tld_pkg::KIND_READER;
                o_plan.count     = 2'd2;
            end else begin
                o_plan.data_q[0] = i_data;
                o_plan.kind_q[0] = tld_pkg::KIND_READER;
                o_plan.count     = 2'd1;
            end
        end else if (i_data == i_cfg.erase_char
                     || (i_data != i_cfg.eof_char && w_did_tr && w_tr == i_cfg.erase_char)) begin
            if (!w_empty) begin
                o_fill_next = i_fill - CW'(1);
                if (w_echo) begin
                    o_plan.data_q[0] = tld_pkg::CH_BS;
                    o_plan.data_q[1] = tld_pkg::CH_SPACE;
                    o_plan.data_q[2] = tld_pkg::CH_BS;
                    o_plan.kind_q[0] = tld_pkg::KIND_DISPLAY;
                    o_plan.kind_q[1] = tld_pkg::KIND_DISPLAY;
                    o_plan.kind_q[2] = tld_pkg::KIND_DISPLAY;
                    o_plan.count     = 2'd3;
                end
            end
        end else if (i_data == i_cfg.eof_char || (w_did_tr && w_tr == i_cfg.eof_char)) begin
            o_plan.flush = !w_empty;
        end else if (w_full) begin
            o_plan.data_q[0] = 8'd0;
            o_plan.kind_q[0] = tld_pkg::KIND_DROPPED;
            o_plan.count     = 2'd1;
        end else begin
            o_plan.store      = 1'b1;
            o_plan.store_byte = w_st;
            o_plan.flush      = (w_st == tld_pkg::CH_NL);
            o_fill_next       = i_fill + CW'(1);
            if (w_echo) begin
                o_plan.data_q[0] = w_disp_st.first;
                o_plan.kind_q[0] = tld_pkg::KIND_DISPLAY;
                o_plan.data_q[1] = w_disp_st.second;
                o_plan.kind_q[1] = tld_pkg::KIND_DISPLAY;
                o_plan.count     = w_disp_st.two ? 2'd2 : 2'd1;
            end
        end
    end

endmodule

### rtl/terminal_line_discipline_top.sv
// Canonical-mode terminal line discipline. Each beat on the slave stream is
// one byte: tuser says whether it was typed at the terminal (0) or written by
// the program for display (1). Every result leaves on the master stream as one
// beat whose tuser gives the kind (reader, display, dropped) and whose tlast
// marks the final beat caused by that input byte; a byte that causes nothing
// (erase or end-of-file on an empty line) produces no beat at all. The block
// handles one byte at a time: a byte is accepted from idle, decoded in the
// next cycle, and its results then leave through a single output register at
// one beat per cycle while the receiver is ready. The line flush is the long
// path: it walks the line store one entry per cycle, again only while the
// receiver is ready, through its single registered read port. Configuration
// registers are written through the plain write port and should only change
// while the block is idle. The line store needs no clearing after reset,
// since only entries that were written since the last flush are ever read
// back.
module terminal_line_discipline_top #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tld_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    // Input bytes.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tuser,  // [0] action
    input  logic                            s_axis_tlast,  // write_end

    // Result beats.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                      m_axis_tuser,  // [1:0] kind
    output logic                            m_axis_tlast   // last
);

    // Fill counter holds 0..LINE_DEPTH; the store address needs one bit less
    // when the depth is a power of two.
    localparam int CW        = $clog2(LINE_DEPTH + 1);
    localparam int AW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << AW;

    tld_pkg::t_state r_state, n_state;
    tld_pkg::t_cfg   r_cfg;
    tld_pkg::t_plan  r_plan;
    tld_pkg::t_plan  w_plan;

    logic            r_in_action;
    logic [7:0]      r_in_data;
    logic [1:0]      r_pos, n_pos;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   w_fill_next;
    logic [CW-1:0]   r_idx, n_idx;
    logic [7:0]      r_mem [MEM_DEPTH];
    logic [7:0]      r_rd_data;

    logic            r_out_valid;
    logic [7:0]      r_out_data;
    logic [1:0]      r_out_kind;
    logic            r_out_last;

    logic            w_out_free;
    logic            w_flush_end;
    logic            w_load;
    logic [7:0]      w_load_data;
    logic [1:0]      w_load_kind;
    logic            w_load_last;

    // Decoding of one byte into its plan is kept in its own unit.
    tld_decode #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_decode (
        .i_cfg       (r_cfg),
        .i_action    (r_in_action),
        .i_data      (r_in_data),
        .i_fill      (r_fill),
        .o_plan      (w_plan),
        .o_fill_next (w_fill_next)
    );

    assign s_axis_tready = (r_state == tld_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // The output register may take a new beat when empty or being drained.
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_flush_end = ((r_idx + CW'(1)) == r_fill);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tld_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = tld_pkg::ST_DECODE;
                end
            end
            tld_pkg::ST_DECODE: begin
                n_state = tld_pkg::ST_EMIT;
            end
            tld_pkg::ST_EMIT: begin
                if (r_pos == r_plan.count) begin
                    n_state = r_plan.flush ? tld_pkg::ST_FLUSH : tld_pkg::ST_IDLE;
                end
            end
            tld_pkg::ST_FLUSH: begin
                if (w_out_free && w_flush_end) begin
                    n_state = tld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tld_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. During the flush the read address runs one step
    // ahead, so the registered read data always holds the entry at r_idx.
    always_comb begin
        w_load      = 1'b0;
        w_load_data = r_rd_data;
        w_load_kind = tld_pkg::KIND_READER;
        w_load_last = 1'b0;
        n_pos       = r_pos;
        n_idx       = '0;
        n_fill      = r_fill;
        case (r_state)
            tld_pkg::ST_IDLE: begin
            end
            tld_pkg::ST_DECODE: begin
                n_pos  = 2'd0;
                n_fill = w_fill_next;
            end
            tld_pkg::ST_EMIT: begin
                if (r_pos != r_plan.count && w_out_free) begin
                    w_load      = 1'b1;
                    w_load_data = r_plan.data_q[r_pos];
                    w_load_kind = r_plan.kind_q[r_pos];
                    w_load_last = (r_pos == r_plan.count - 2'd1) && !r_plan.flush;
                    n_pos       = r_pos + 2'd1;
                end
            end
            tld_pkg::ST_FLUSH: begin
                n_idx = r_idx;
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_last = w_flush_end;
                    n_idx       = r_idx + CW'(1);
                    if (w_flush_end) begin
                        n_fill = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tld_pkg::ST_IDLE;
            r_pos       <= 2'd0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_modes  <= tld_pkg::RST_LOCAL_MODES;
            r_cfg.input_modes  <= tld_pkg::RST_INPUT_MODES;
            r_cfg.output_modes <= tld_pkg::RST_OUTPUT_MODES;
            r_cfg.erase_char   <= tld_pkg::RST_ERASE_CHAR;
            r_cfg.eof_char     <= tld_pkg::RST_EOF_CHAR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tld_pkg::REG_LOCAL_MODES:  r_cfg.local_modes  <= i_cfg_data[1:0];
                tld_pkg::REG_INPUT_MODES:  r_cfg.input_modes  <= i_cfg_data[1:0];
                tld_pkg::REG_OUTPUT_MODES: r_cfg.output_modes <= i_cfg_data[2:0];
                tld_pkg::REG_ERASE_CHAR:   r_cfg.erase_char   <= i_cfg_data;
                tld_pkg::REG_EOF_CHAR:     r_cfg.eof_char     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Payload registers: input capture, decoded plan and the output beat.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_data   <= s_axis_tdata;
        end
        if (r_state == tld_pkg::ST_DECODE) begin
            r_plan <= w_plan;
        end
        if (w_load) begin
            r_out_data <= w_load_data;
            r_out_kind <= w_load_kind;
            r_out_last <= w_load_last;
        end
    end

    // Line store: one write port in the decode cycle, one registered read.
    // The store never happens in the same cycle as the first flush read.
    always_ff @(posedge i_clk) begin
        if (r_state == tld_pkg::ST_DECODE && w_plan.store) begin
            r_mem[r_fill[AW-1:0]] <= w_plan.store_byte;
        end
        r_rd_data <= r_mem[n_idx[AW-1:0]];
    end

endmodule

### test/line_discipline_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the line discipline, keeps
// its own copy of the line buffer and registers, and checks every result beat
// against the oldest beat still awaited.
module line_discipline_checker #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tld_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tuser,   // [0] action

    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
    input  logic [1:0]                      m_axis_tuser,   // [1:0] kind
    input  logic                            m_axis_tlast,   // last

    output int                              o_fail_count,
    output int                              o_pending
);

    localparam logic ACT_PROGRAM = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_beat;

    t_beat         awaited_beats[$];
    t_beat         want;
    tld_pkg::t_cfg regs;
    logic [7:0]    line_buf [LINE_DEPTH];
    logic [5:0]    line_fill;
    int            fail_total = 0;

    task automatic push_beat(input logic [1:0] kind, input logic [7:0] value);
        t_beat b;
        b.kind  = kind;
        b.value = value;
        b.last  = 1'b0;
        awaited_beats.push_back(b);
    endtask

    // Display path, shared by program output and the canonical-mode echo of typed bytes.
    task automatic show_byte(input logic [7:0] c);
        if (!regs.output_modes[0]) begin
            push_beat(tld_pkg::KIND_DISPLAY, c);
        end else if (c == tld_pkg::CH_NL && regs.output_modes[1]) begin
            push_beat(tld_pkg::KIND_DISPLAY, tld_pkg::CH_CR);
            push_beat(tld_pkg::KIND_DISPLAY, tld_pkg::CH_NL);
        end else if (c == tld_pkg::CH_CR && regs.output_modes[2]) begin
            push_beat(tld_pkg::KIND_DISPLAY, tld_pkg::CH_NL);
        end else begin
            push_beat(tld_pkg::KIND_DISPLAY, c);
        end
    endtask

    task automatic release_line();
        for (int i = 0; i < int'(line_fill); i++)
            push_beat(tld_pkg::KIND_READER, line_buf[i]);
        line_fill = '0;
    endtask

    // Handles the erase and end-of-file bytes; taken tells whether c was one.
    task automatic erase_or_eof(input logic [7:0] c, output logic taken);
        taken = 1'b1;
        if (c == regs.erase_char) begin
            if (line_fill != '0) begin
                line_fill = line_fill - 6'd1;
                if (regs.local_modes[1]) begin
                    show_byte(tld_pkg::CH_BS);
                    show_byte(tld_pkg::CH_SPACE);
                    show_byte(tld_pkg::CH_BS);
                end
            end
        end else if (c == regs.eof_char) begin
            if (line_fill != '0)
                release_line();
        end else begin
            taken = 1'b0;
        end
    endtask

    task automatic edit_typed_byte(input logic [7:0] c);
        logic [7:0] ch;
        logic       taken;
        ch = c;
        erase_or_eof(ch, taken);
        // A newline or return is swapped at most once, then looked at again.
        if (!taken) begin
            if (ch == tld_pkg::CH_NL && regs.input_modes[0]) begin
                ch = tld_pkg::CH_CR;
                erase_or_eof(ch, taken);
            end else if (ch == tld_pkg::CH_CR && regs.input_modes[1]) begin
                ch = tld_pkg::CH_NL;
                erase_or_eof(ch, taken);
            end
        end
        if (!taken) begin
            if (ch == tld_pkg::CH_ESC)
                ch = tld_pkg::CH_CARET;
            if (int'(line_fill) >= LINE_DEPTH) begin
                push_beat(tld_pkg::KIND_DROPPED, 8'h00);
            end else begin
                if (regs.local_modes[1])
                    show_byte(ch);
                line_buf[line_fill] = ch;
                line_fill = line_fill + 6'd1;
                if (ch == tld_pkg::CH_NL)
                    release_line();
            end
        end
    endtask

    task automatic predict_byte(input logic action, input logic [7:0] c);
        int    first;
        t_beat tail;
        first = awaited_beats.size();
        if (action == ACT_PROGRAM) begin
            show_byte(c);
        end else if (regs.local_modes[0]) begin
            edit_typed_byte(c);
        end else begin
            if (regs.local_modes[1])
                push_beat(tld_pkg::KIND_DISPLAY, c);
            push_beat(tld_pkg::KIND_READER, c);
        end
        if (awaited_beats.size() > first) begin
            tail = awaited_beats.pop_back();
            tail.last = 1'b1;
            awaited_beats.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.local_modes  = tld_pkg::RST_LOCAL_MODES;
            regs.input_modes  = tld_pkg::RST_INPUT_MODES;
            regs.output_modes = tld_pkg::RST_OUTPUT_MODES;
            regs.erase_char   = tld_pkg::RST_ERASE_CHAR;
            regs.eof_char     = tld_pkg::RST_EOF_CHAR;
            line_fill = '0;
            awaited_beats.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_beats.size() == 0) begin
                    $error("unexpected result beat: kind %0d, out_byte 0x%02h, last %0d",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_total++;
                end else begin
                    want = awaited_beats.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                        fail_total++;
                    end
                    if (m_axis_tdata !== want.value) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.value, m_axis_tdata);
                        fail_total++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tld_pkg::REG_LOCAL_MODES:  regs.local_modes  = i_cfg_data[1:0];
                    tld_pkg::REG_INPUT_MODES:  regs.input_modes  = i_cfg_data[1:0];
                    tld_pkg::REG_OUTPUT_MODES: regs.output_modes = i_cfg_data[2:0];
                    tld_pkg::REG_ERASE_CHAR:   regs.erase_char   = i_cfg_data[7:0];
                    tld_pkg::REG_EOF_CHAR:     regs.eof_char     = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tuser, s_axis_tdata);
        end
        o_pending    = awaited_beats.size();
        o_fail_count = fail_total;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

// Top of the line discipline test. This module only makes stimulus and gives
// the verdict; the checker beside the block predicts and compares every beat.
module testbench;

    localparam logic ACT_TYPED   = 1'b0;
    localparam logic ACT_PROGRAM = 1'b1;

    // The slowest correct run is far below this: about 430 bytes, each at
    // worst a full line release stalled by the sparsest receiver pattern.
    localparam int CYCLE_LIMIT    = 400000;
    // Length of the one long receiver hold-off that backs up the block.
    localparam int RX_HOLD_CYCLES = 300;
    // Quiet time after the last awaited beat. A byte that yields nothing
    // (erase or end-of-file on an empty line) still passes through the decode and emit states.
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 45;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } t_rx_pattern;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tld_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tld_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;   // [7:0] data_byte
    logic                           s_axis_tuser;   // [0] action
    logic                           s_axis_tlast;   // write_end

    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;   // [7:0] out_byte
    logic [1:0]                     m_axis_tuser;   // [1:0] kind
    logic                           m_axis_tlast;   // last

    int                             fail_count;
    int                             results_pending;

    // Shadow of the erase and end-of-file bytes, used only to shape stimulus.
    logic [7:0]                     erase_now = tld_pkg::RST_ERASE_CHAR;
    logic [7:0]                     eof_now   = tld_pkg::RST_EOF_CHAR;

    // Sender burst bookkeeping and the request for the long receiver hold.
    int                             burst_left = 0;
    int                             items_sent = 0;
    logic                           rx_hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    terminal_line_discipline_top #(
        .LINE_DEPTH    (tld_pkg::LINE_DEPTH_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    line_discipline_checker #(
        .LINE_DEPTH    (tld_pkg::LINE_DEPTH_DEF)
    ) line_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending)
    );

    // Offers one byte and returns at the falling edge after its beat was
    // taken. Valid stays high from one byte to the next inside a burst; it
    // only drops for a gap between bursts, and some bursts start with no gap
    // at all so that long back-to-back stretches also occur.
    task automatic send_byte(input logic action, input logic [7:0] c, input logic wend);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tuser  = action;
        s_axis_tlast  = wend;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Registers may only change while the block is idle, so the sender stops
    // and waits for every awaited beat plus a short settling time.
    task automatic wait_for_idle();
        s_axis_tvalid = 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tld_pkg::CFG_IDX_W-1:0] index,
                             input logic [tld_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [1:0] lmodes, input logic [1:0] imodes,
                             input logic [2:0] omodes, input logic [7:0] erase_c,
                             input logic [7:0] eof_c);
        wait_for_idle();
        write_reg(tld_pkg::REG_LOCAL_MODES,  {6'd0, lmodes});
        write_reg(tld_pkg::REG_INPUT_MODES,  {6'd0, imodes});
        write_reg(tld_pkg::REG_OUTPUT_MODES, {5'd0, omodes});
        write_reg(tld_pkg::REG_ERASE_CHAR,   erase_c);
        write_reg(tld_pkg::REG_EOF_CHAR,     eof_c);
        erase_now = erase_c;
        eof_now   = eof_c;
    endtask

    // An ordinary line byte: never the erase or end-of-file byte and never a
    // newline or return, so that it is stored. Escape is favored a little.
    function automatic logic [7:0] line_content();
        logic [7:0] c;
        c = ($urandom_range(0, 19) == 0) ? tld_pkg::CH_ESC : 8'($urandom_range(0, 255));
        while (c == erase_now || c == eof_now || c == tld_pkg::CH_NL || c == tld_pkg::CH_CR)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Candidates for the erase and end-of-file registers in random phases.
    function automatic logic [7:0] pick_control_byte();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = tld_pkg::RST_ERASE_CHAR;
            1: c = tld_pkg::RST_EOF_CHAR;
            2: c = tld_pkg::CH_CR;
            3: c = tld_pkg::CH_NL;
            4: c = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Most of the traffic is well-formed typed lines, some of them long
    // enough to fill the line buffer, with the occasional erase and one of
    // several endings. The rest is program writes rich in newlines and
    // returns, plus plain noise on either side.
    task automatic random_phase(input int n_items);
        int         target;
        int         len;
        int         pick;
        logic [7:0] c;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10)
                                                 : $urandom_range(30, 45);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_byte(ACT_TYPED, erase_now, 1'($urandom_range(0, 1)));
                    else
                        send_byte(ACT_TYPED, line_content(), 1'($urandom_range(0, 1)));
                end
                case ($urandom_range(0, 3))
                    0: send_byte(ACT_TYPED, tld_pkg::CH_NL, 1'($urandom_range(0, 1)));
                    1: send_byte(ACT_TYPED, tld_pkg::CH_CR, 1'($urandom_range(0, 1)));
                    2: send_byte(ACT_TYPED, eof_now, 1'($urandom_range(0, 1)));
                    default: ;
                endcase
            end else if (pick < 80) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        c = ($urandom_range(0, 1) != 0) ? tld_pkg::CH_NL : tld_pkg::CH_CR;
                    else
                        c = 8'($urandom_range(0, 255));
                    send_byte(ACT_PROGRAM, c, i == len - 1);
                end
            end else begin
                send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Receiver: switches among readiness patterns at random, from always
    // ready down to one beat in four. On request it holds ready low
    // for a long stretch, counted here, while the sender keeps offering bytes.
    initial begin : receiver
        t_rx_pattern rx_pattern;
        int          rx_left;
        m_axis_tready = 1'b0;
        rx_pattern    = RX_OPEN;
        rx_left       = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req   = 1'b0;
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (rx_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_left    = $urandom_range(20, 80);
            end
            rx_left--;
            case (rx_pattern)
                RX_OPEN:   m_axis_tready = 1'b1;
                RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                default:   m_axis_tready = (rx_left % 3 != 0);
            endcase
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] erase_pick;
        logic [7:0] eof_pick;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings: canonical with echo, typed
        // return becomes newline, newline shown as return plus newline.
        // Erase and end-of-file on an empty line must give nothing at all.
        send_byte(ACT_TYPED, tld_pkg::RST_ERASE_CHAR, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::RST_EOF_CHAR, 1'b0);
        // Extreme bytes and escape into the line, then erase one and flush.
        send_byte(ACT_TYPED, 8'h00, 1'b0);
        send_byte(ACT_TYPED, 8'hFF, 1'b1);
        send_byte(ACT_TYPED, tld_pkg::CH_ESC, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::RST_ERASE_CHAR, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::RST_EOF_CHAR, 1'b1);
        // A return translated to newline ends the line; so does a newline.
        send_byte(ACT_TYPED, "x", 1'b0);
        send_byte(ACT_TYPED, tld_pkg::CH_CR, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::CH_NL, 1'b0);
        // Program output through the display post-processing.
        send_byte(ACT_PROGRAM, tld_pkg::CH_NL, 1'b0);
        send_byte(ACT_PROGRAM, tld_pkg::CH_CR, 1'b0);
        send_byte(ACT_PROGRAM, 8'h00, 1'b0);
        send_byte(ACT_PROGRAM, 8'hFF, 1'b1);

        // No echo, typed newline becomes return, and return is the erase
        // byte, so the translated byte must be caught as an erase.
        configure(2'd1, 2'd1, 3'd7, tld_pkg::CH_CR, 8'h00);
        send_byte(ACT_TYPED, "a", 1'b0);
        send_byte(ACT_TYPED, "b", 1'b0);
        send_byte(ACT_TYPED, "c", 1'b0);
        send_byte(ACT_TYPED, tld_pkg::CH_NL, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::CH_CR, 1'b0);
        send_byte(ACT_TYPED, 8'h00, 1'b1);
        send_byte(ACT_PROGRAM, tld_pkg::CH_CR, 1'b0);
        send_byte(ACT_PROGRAM, tld_pkg::CH_NL, 1'b1);

        // Raw mode with echo: bytes pass untouched, escape included.
        configure(2'd2, 2'd0, 3'd0, 8'hFF, tld_pkg::RST_EOF_CHAR);
        send_byte(ACT_TYPED, tld_pkg::CH_ESC, 1'b0);
        send_byte(ACT_TYPED, tld_pkg::RST_EOF_CHAR, 1'b1);
        send_byte(ACT_PROGRAM, tld_pkg::CH_NL, 1'b1);

        // Random phases. Every register is rewritten at each phase change,
        // which also makes the sender wait until all results are in.
        configure(2'd3, 2'd3, 3'd7, tld_pkg::CH_CR, tld_pkg::RST_EOF_CHAR);
        random_phase(PHASE_ITEMS);
        // Typed return turns into newline, which is here the end-of-file byte.
        configure(2'd3, 2'd2, 3'd1, tld_pkg::RST_ERASE_CHAR, tld_pkg::CH_NL);
        random_phase(PHASE_ITEMS);
        // Raw mode without echo: every byte yields a beat, so the long
        // receiver hold-off backs the block up and stalls its input.
        configure(2'd0, 2'd0, 3'd0, 8'h00, 8'hFF);
        rx_hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        configure(2'd2, 2'd1, 3'd7, 8'hFF, 8'h00);
        random_phase(PHASE_ITEMS);
        configure(2'd1, 2'd3, 3'd5, tld_pkg::CH_BS, tld_pkg::RST_EOF_CHAR);
        random_phase(PHASE_ITEMS);
        configure(2'd3, 2'd0, 3'd3, tld_pkg::RST_ERASE_CHAR, tld_pkg::RST_EOF_CHAR);
        random_phase(PHASE_ITEMS);
        repeat (3) begin
            erase_pick = pick_control_byte();
            eof_pick   = pick_control_byte();
            if (eof_pick == erase_pick)
                eof_pick = erase_pick + 8'd1;
            configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      3'($urandom_range(0, 7)), erase_pick, eof_pick);
            random_phase(PHASE_ITEMS);
        end

        // Drain, let any stray beat show up, then give the verdict.
        wait_for_idle();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
